>>> rtl/core/bsc_pkg.sv
// Shared types, constants and the sequencer microcode for the barometric
// compensation core. No dependencies.
package bsc_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned RawW    = 20;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DataW-1:0] FineOffset = 64'd128000;
  localparam logic [DataW-1:0] PressFull  = 64'd1048576;
  localparam logic [DataW-1:0] PressScale = 64'd3125;
  localparam logic [DataW-1:0] OneQ47     = 64'd1 << 47;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_COEFFS = 2'd0,
    CFG_PRESS_LO    = 2'd1,
    CFG_PRESS_HI    = 2'd2,
    CFG_PRESS_NINE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DABS,
    S_DIV,
    S_DNEG,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ASR,
    OP_SHL,
    OP_MUL,
    OP_DIV,
    OP_DZCHK,
    OP_END
  } op_t;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_V1,
    SRC_V2,
    SRC_D,
    SRC_P,
    SRC_H,
    SRC_T,
    SRC_ADC,
    SRC_ADC3,
    SRC_ADC4,
    SRC_T1X2,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_P1,
    SRC_P2,
    SRC_P3,
    SRC_P4,
    SRC_P5,
    SRC_P6,
    SRC_P7,
    SRC_P8,
    SRC_P9,
    SRC_FINE,
    SRC_K128000,
    SRC_K2P47,
    SRC_K2P20,
    SRC_K3125
  } src_t;

  typedef enum logic [2:0] {
    DST_V1,
    DST_V2,
    DST_D,
    DST_P,
    DST_H,
    DST_T
  } dst_t;

  // One sequencer step. len holds multiplier bit count minus one.
  typedef struct packed {
    op_t        op;
    src_t       a;
    src_t       b;
    dst_t       dst;
    logic [5:0] sh;
    logic [5:0] len;
  } uop_t;

  localparam logic [5:0] PcPress = 6'd0;
  localparam logic [5:0] PcTemp  = 6'd40;

  function automatic uop_t mk(op_t op, src_t a, src_t b, dst_t dst,
                              logic [5:0] sh, logic [5:0] len);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    u.sh  = sh;
    u.len = len;
    return u;
  endfunction

  // Microprogram: pressure at PcPress, temperature at PcTemp
  function automatic uop_t ucode(logic [5:0] pc);
    uop_t u;
    u = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_T, 6'd0, 6'd0);
    unique case (pc)
      6'd0:  u = mk(OP_SUB, SRC_FINE, SRC_K128000, DST_V1, 6'd0, 6'd0);
      6'd1:  u = mk(OP_MUL, SRC_V1, SRC_V1, DST_H, 6'd0, 6'd63);
      6'd2:  u = mk(OP_MUL, SRC_H, SRC_P6, DST_V2, 6'd0, 6'd15);
      6'd3:  u = mk(OP_MUL, SRC_V1, SRC_P5, DST_T, 6'd0, 6'd15);
      6'd4:  u = mk(OP_SHL, SRC_T, SRC_ZERO, DST_T, 6'd17, 6'd0);
      6'd5:  u = mk(OP_ADD, SRC_V2, SRC_T, DST_V2, 6'd0, 6'd0);
      6'd6:  u = mk(OP_SHL, SRC_P4, SRC_ZERO, DST_T, 6'd35, 6'd0);
      6'd7:  u = mk(OP_ADD, SRC_V2, SRC_T, DST_V2, 6'd0, 6'd0);
      6'd8:  u = mk(OP_MUL, SRC_H, SRC_P3, DST_D, 6'd0, 6'd15);
      6'd9:  u = mk(OP_ASR, SRC_D, SRC_ZERO, DST_D, 6'd8, 6'd0);
      6'd10: u = mk(OP_MUL, SRC_V1, SRC_P2, DST_T, 6'd0, 6'd15);
      6'd11: u = mk(OP_SHL, SRC_T, SRC_ZERO, DST_T, 6'd12, 6'd0);
      6'd12: u = mk(OP_ADD, SRC_D, SRC_T, DST_D, 6'd0, 6'd0);
      6'd13: u = mk(OP_ADD, SRC_D, SRC_K2P47, DST_D, 6'd0, 6'd0);
      6'd14: u = mk(OP_MUL, SRC_D, SRC_P1, DST_D, 6'd0, 6'd16);
      6'd15: u = mk(OP_ASR, SRC_D, SRC_ZERO, DST_D, 6'd33, 6'd0);
      6'd16: u = mk(OP_DZCHK, SRC_D, SRC_ZERO, DST_D, 6'd0, 6'd0);
      6'd17: u = mk(OP_SUB, SRC_K2P20, SRC_ADC, DST_P, 6'd0, 6'd0);
      6'd18: u = mk(OP_SHL, SRC_P, SRC_ZERO, DST_P, 6'd31, 6'd0);
      6'd19: u = mk(OP_SUB, SRC_P, SRC_V2, DST_P, 6'd0, 6'd0);
      6'd20: u = mk(OP_MUL, SRC_P, SRC_K3125, DST_P, 6'd0, 6'd12);
      6'd21: u = mk(OP_DIV, SRC_P, SRC_D, DST_P, 6'd0, 6'd0);
      6'd22: u = mk(OP_ASR, SRC_P, SRC_ZERO, DST_H, 6'd13, 6'd0);
      6'd23: u = mk(OP_MUL, SRC_H, SRC_P9, DST_T, 6'd0, 6'd15);
      6'd24: u = mk(OP_MUL, SRC_T, SRC_H, DST_T, 6'd0, 6'd63);
      6'd25: u = mk(OP_ASR, SRC_T, SRC_ZERO, DST_T, 6'd25, 6'd0);
      6'd26: u = mk(OP_MUL, SRC_P, SRC_P8, DST_V1, 6'd0, 6'd15);
      6'd27: u = mk(OP_ASR, SRC_V1, SRC_ZERO, DST_V1, 6'd19, 6'd0);
      6'd28: u = mk(OP_ADD, SRC_P, SRC_T, DST_P, 6'd0, 6'd0);
      6'd29: u = mk(OP_ADD, SRC_P, SRC_V1, DST_P, 6'd0, 6'd0);
      6'd30: u = mk(OP_ASR, SRC_P, SRC_ZERO, DST_P, 6'd8, 6'd0);
      6'd31: u = mk(OP_SHL, SRC_P7, SRC_ZERO, DST_T, 6'd4, 6'd0);
      6'd32: u = mk(OP_ADD, SRC_P, SRC_T, DST_P, 6'd0, 6'd0);
      6'd40: u = mk(OP_SUB, SRC_ADC3, SRC_T1X2, DST_T, 6'd0, 6'd0);
      6'd41: u = mk(OP_MUL, SRC_T, SRC_T2, DST_T, 6'd0, 6'd15);
      6'd42: u = mk(OP_ASR, SRC_T, SRC_ZERO, DST_T, 6'd11, 6'd0);
      6'd43: u = mk(OP_SUB, SRC_ADC4, SRC_T1, DST_V2, 6'd0, 6'd0);
      6'd44: u = mk(OP_MUL, SRC_V2, SRC_V2, DST_V2, 6'd0, 6'd17);
      6'd45: u = mk(OP_ASR, SRC_V2, SRC_ZERO, DST_V2, 6'd12, 6'd0);
      6'd46: u = mk(OP_MUL, SRC_V2, SRC_T3, DST_V2, 6'd0, 6'd15);
      6'd47: u = mk(OP_ASR, SRC_V2, SRC_ZERO, DST_V2, 6'd14, 6'd0);
      6'd48: u = mk(OP_ADD, SRC_T, SRC_V2, DST_T, 6'd0, 6'd0);
      default: u = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_T, 6'd0, 6'd0);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/bsc_stream_if.sv
// Valid/ready channel interfaces for the compensation core.
// Depends on nothing.
interface bsc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [19:0] raw_sample;
  modport source(output valid, func, raw_sample, input ready);
  modport sink(input valid, func, raw_sample, output ready);
endinterface

interface bsc_out_if;
  logic               valid;
  logic               ready;
  logic               sample_kind;
  logic signed [31:0] fine_temperature;
  logic        [31:0] pressure_q24_8;
  logic               divide_by_zero;
  modport source(output valid, sample_kind, fine_temperature, pressure_q24_8,
                 divide_by_zero, input ready);
  modport sink(input valid, sample_kind, fine_temperature, pressure_q24_8,
               divide_by_zero, output ready);
endinterface

>>> rtl/core/barometric_sensor_compensation_core.sv
// Barometric compensation core: one microcoded 64-bit datapath.
// Depends on bsc_pkg and the channel interfaces in bsc_stream_if.sv.
//
// A transaction takes a raw temperature or pressure sample and returns one
// result. All arithmetic runs on a single 64-bit adder plus a constant
// shifter, stepped by a microcode sequencer: multiplies are shift-add, one
// multiplier bit per cycle, and the pressure divide is restoring, one
// quotient bit per cycle. When the divisor is zero the rest of a pressure
// transaction is skipped. The input is ready only while the sequencer
// is idle; a finished result sits in the output register until taken, and
// the sequencer waits at the end of the next transaction if it still is.
// Calibration words must be written over cfg_* only while the core is idle;
// the core itself does not enforce this.
module barometric_sensor_compensation_core (
  input  logic                        clk,
  input  logic                        rst_n,
  bsc_in_if.sink                      in_ch,
  bsc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bsc_pkg::DataW-1:0]   cfg_data
);

  // Configuration
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [15:0] press_nine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      press_nine_r  <= '0;
    end else if (cfg_we) begin
      unique case (bsc_pkg::cfg_idx_t'(cfg_index))
        bsc_pkg::CFG_TEMP_COEFFS: temp_coeffs_r <= cfg_data[47:0];
        bsc_pkg::CFG_PRESS_LO:    press_lo_r    <= cfg_data;
        bsc_pkg::CFG_PRESS_HI:    press_hi_r    <= cfg_data;
        bsc_pkg::CFG_PRESS_NINE:  press_nine_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Sequencer and datapath state
  bsc_pkg::state_t state_r, state_nxt;
  logic [5:0]  pc_r, pc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        func_r, func_nxt;
  logic [19:0] adc_r, adc_nxt;
  logic        dz_r, dz_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] fine_r, fine_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] v1_r, v1_nxt;
  logic [63:0] v2_r, v2_nxt;
  logic [63:0] d_r, d_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] t_r, t_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [31:0] out_fine_r, out_fine_nxt;
  logic [31:0] out_press_r, out_press_nxt;
  logic        out_dz_r, out_dz_nxt;

  bsc_pkg::uop_t uop;
  assign uop = bsc_pkg::ucode(pc_r);

  // Operand select
  function automatic logic [63:0] operand(bsc_pkg::src_t s);
    logic [63:0] r;
    unique case (s)
      bsc_pkg::SRC_ZERO:    r = '0;
      bsc_pkg::SRC_V1:      r = v1_r;
      bsc_pkg::SRC_V2:      r = v2_r;
      bsc_pkg::SRC_D:       r = d_r;
      bsc_pkg::SRC_P:       r = p_r;
      bsc_pkg::SRC_H:       r = h_r;
      bsc_pkg::SRC_T:       r = t_r;
      bsc_pkg::SRC_ADC:     r = {44'd0, adc_r};
      bsc_pkg::SRC_ADC3:    r = {47'd0, adc_r[19:3]};
      bsc_pkg::SRC_ADC4:    r = {48'd0, adc_r[19:4]};
      bsc_pkg::SRC_T1X2:    r = {47'd0, temp_coeffs_r[15:0], 1'b0};
      bsc_pkg::SRC_T1:      r = {48'd0, temp_coeffs_r[15:0]};
      bsc_pkg::SRC_T2:      r = sx16(temp_coeffs_r[31:16]);
      bsc_pkg::SRC_T3:      r = sx16(temp_coeffs_r[47:32]);
      bsc_pkg::SRC_P1:      r = {48'd0, press_lo_r[15:0]};
      bsc_pkg::SRC_P2:      r = sx16(press_lo_r[31:16]);
      bsc_pkg::SRC_P3:      r = sx16(press_lo_r[47:32]);
      bsc_pkg::SRC_P4:      r = sx16(press_lo_r[63:48]);
      bsc_pkg::SRC_P5:      r = sx16(press_hi_r[15:0]);
      bsc_pkg::SRC_P6:      r = sx16(press_hi_r[31:16]);
      bsc_pkg::SRC_P7:      r = sx16(press_hi_r[47:32]);
      bsc_pkg::SRC_P8:      r = sx16(press_hi_r[63:48]);
      bsc_pkg::SRC_P9:      r = sx16(press_nine_r);
      bsc_pkg::SRC_FINE:    r = {{32{fine_r[31]}}, fine_r};
      bsc_pkg::SRC_K128000: r = bsc_pkg::FineOffset;
      bsc_pkg::SRC_K2P47:   r = bsc_pkg::OneQ47;
      bsc_pkg::SRC_K2P20:   r = bsc_pkg::PressFull;
      bsc_pkg::SRC_K3125:   r = bsc_pkg::PressScale;
      default:              r = '0;
    endcase
    return r;
  endfunction

  logic [63:0] opa, opb;
  always_comb begin
    opa = operand(uop.a);
    opb = operand(uop.b);
  end

  // Shared adder
  logic [63:0] add_a, add_b;
  logic        add_sub;
  logic [64:0] add_sum;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {64{add_sub}}} + {64'd0, add_sub};

  // Constant shifter
  logic [63:0] sh_res;
  always_comb begin
    if (uop.op == bsc_pkg::OP_ASR) begin
      sh_res = $unsigned($signed(opa) >>> uop.sh);
    end else begin
      sh_res = opa << uop.sh;
    end
  end

  // Division trial remainder
  logic [63:0] div_shift;
  assign div_shift = {acc_r[62:0], y_r[63]};

  // Result write-back
  logic        wr_en;
  logic [63:0] wr_data;

  // Pressure clamp to unsigned 32 bits
  logic [31:0] press_clamped;
  always_comb begin
    if (p_r[63]) begin
      press_clamped = '0;
    end else if (|p_r[62:32]) begin
      press_clamped = '1;
    end else begin
      press_clamped = p_r[31:0];
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    adc_nxt       = adc_r;
    dz_nxt        = dz_r;
    neg_nxt       = neg_r;
    fine_nxt      = fine_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_fine_nxt  = out_fine_r;
    out_press_nxt = out_press_r;
    out_dz_nxt    = out_dz_r;
    add_a         = opa;
    add_b         = opb;
    add_sub       = 1'b0;
    wr_en         = 1'b0;
    wr_data       = add_sum[63:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bsc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          adc_nxt   = in_ch.raw_sample;
          dz_nxt    = 1'b0;
          pc_nxt    = in_ch.func ? bsc_pkg::PcPress : bsc_pkg::PcTemp;
          state_nxt = bsc_pkg::S_EXEC;
        end
      end

      bsc_pkg::S_EXEC: begin
        unique case (uop.op)
          bsc_pkg::OP_ADD, bsc_pkg::OP_SUB: begin
            add_sub = (uop.op == bsc_pkg::OP_SUB);
            wr_en   = 1'b1;
            pc_nxt  = pc_r + 6'd1;
          end
          bsc_pkg::OP_ASR, bsc_pkg::OP_SHL: begin
            wr_en   = 1'b1;
            wr_data = sh_res;
            pc_nxt  = pc_r + 6'd1;
          end
          bsc_pkg::OP_MUL: begin
            acc_nxt   = '0;
            x_nxt     = opa;
            y_nxt     = opb;
            cnt_nxt   = uop.len;
            state_nxt = bsc_pkg::S_MUL;
          end
          bsc_pkg::OP_DIV: begin
            // magnitude of the dividend
            add_a     = '0;
            add_b     = opa;
            add_sub   = opa[63];
            y_nxt     = opa[63] ? add_sum[63:0] : opa;
            neg_nxt   = opa[63] ^ opb[63];
            state_nxt = bsc_pkg::S_DABS;
          end
          bsc_pkg::OP_DZCHK: begin
            if (opa == '0) begin
              dz_nxt    = 1'b1;
              state_nxt = bsc_pkg::S_DONE;
            end else begin
              pc_nxt = pc_r + 6'd1;
            end
          end
          bsc_pkg::OP_END: begin
            state_nxt = bsc_pkg::S_DONE;
          end
          default: state_nxt = bsc_pkg::S_DONE;
        endcase
      end

      // Shift-add multiply; the top multiplier bit carries negative weight
      bsc_pkg::S_MUL: begin
        add_a   = acc_r;
        add_b   = x_r;
        add_sub = (cnt_r == '0);
        acc_nxt = y_r[0] ? add_sum[63:0] : acc_r;
        x_nxt   = {x_r[62:0], 1'b0};
        y_nxt   = {1'b0, y_r[63:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          wr_en     = 1'b1;
          wr_data   = acc_nxt;
          pc_nxt    = pc_r + 6'd1;
          state_nxt = bsc_pkg::S_EXEC;
        end
      end

      // Magnitude of the divisor
      bsc_pkg::S_DABS: begin
        add_a     = '0;
        add_b     = opb;
        add_sub   = opb[63];
        x_nxt     = opb[63] ? add_sum[63:0] : opb;
        acc_nxt   = '0;
        cnt_nxt   = 6'd63;
        state_nxt = bsc_pkg::S_DIV;
      end

      // Restoring divide, one quotient bit per cycle
      bsc_pkg::S_DIV: begin
        add_a   = div_shift;
        add_b   = x_r;
        add_sub = 1'b1;
        acc_nxt = add_sum[64] ? add_sum[63:0] : div_shift;
        y_nxt   = {y_r[62:0], add_sum[64]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = bsc_pkg::S_DNEG;
        end
      end

      // Apply quotient sign
      bsc_pkg::S_DNEG: begin
        add_a     = '0;
        add_b     = y_r;
        add_sub   = neg_r;
        wr_en     = 1'b1;
        pc_nxt    = pc_r + 6'd1;
        state_nxt = bsc_pkg::S_EXEC;
      end

      // Hand the result to the output register once it is free
      bsc_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = func_r;
          if (!func_r) begin
            fine_nxt      = t_r[31:0];
            out_fine_nxt  = t_r[31:0];
            out_press_nxt = '0;
          end else begin
            out_fine_nxt  = fine_r;
            out_press_nxt = dz_r ? 32'd0 : press_clamped;
          end
          out_dz_nxt = dz_r;
          state_nxt  = bsc_pkg::S_IDLE;
        end
      end

      default: state_nxt = bsc_pkg::S_IDLE;
    endcase
  end

  // Write-back decode
  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    d_nxt  = d_r;
    p_nxt  = p_r;
    h_nxt  = h_r;
    t_nxt  = t_r;
    if (wr_en) begin
      unique case (uop.dst)
        bsc_pkg::DST_V1: v1_nxt = wr_data;
        bsc_pkg::DST_V2: v2_nxt = wr_data;
        bsc_pkg::DST_D:  d_nxt  = wr_data;
        bsc_pkg::DST_P:  p_nxt  = wr_data;
        bsc_pkg::DST_H:  h_nxt  = wr_data;
        bsc_pkg::DST_T:  t_nxt  = wr_data;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsc_pkg::S_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      dz_r        <= 1'b0;
      fine_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      dz_r        <= dz_nxt;
      fine_r      <= fine_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    adc_r       <= adc_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    v1_r        <= v1_nxt;
    v2_r        <= v2_nxt;
    d_r         <= d_nxt;
    p_r         <= p_nxt;
    h_r         <= h_nxt;
    t_r         <= t_nxt;
    out_kind_r  <= out_kind_nxt;
    out_fine_r  <= out_fine_nxt;
    out_press_r <= out_press_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  // Ports
  assign in_ch.ready             = (state_r == bsc_pkg::S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.sample_kind      = out_kind_r;
  assign out_ch.fine_temperature = out_fine_r;
  assign out_ch.pressure_q24_8   = out_press_r;
  assign out_ch.divide_by_zero   = out_dz_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still ready after a transaction was taken");

  a_dz_is_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_kind_r && (out_press_r == '0))
    else $error("divide-by-zero flag on a bad result");

  a_temp_no_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |-> (out_press_r == '0) && !out_dz_r)
    else $error("temperature result carries pressure data");

  a_fine_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_fine_r == fine_r)
    else $error("reported fine temperature differs from stored value");

endmodule
